>>> hdl/tcbv_pkg.sv
package tcbv_pkg;

  // per-byte vote outcome
  typedef enum logic [2:0] {
    ST_AGREE      = 3'd0,
    ST_INV_FIXED  = 3'd1,
    ST_COPY_FIXED = 3'd2,
    ST_DATA_FIXED = 3'd3,
    ST_UNRECOV    = 3'd4
  } status_t;

  // operating modes, code three behaves as check
  localparam logic [1:0] MODE_CHECK   = 2'd0;
  localparam logic [1:0] MODE_REPAIR  = 2'd1;
  localparam logic [1:0] MODE_REFRESH = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE         = 1'b0;
  localparam logic REG_EXPECTED_TAG = 1'b1;

  localparam logic [7:0]  BYTE_ONES = 8'hff;
  localparam logic [15:0] SUM_ONES  = 16'hffff;

  // result of the byte vote and repair
  typedef struct packed {
    logic [7:0] fixed_data;
    logic [7:0] fixed_copy;
    logic [7:0] fixed_inverted;
    status_t    status;
    logic       unrecov;
  } vote_res_t;

  // end-of-record flags
  typedef struct packed {
    logic tag_error;
    logic mem_error;
    logic data_error;
  } rec_flags_t;

endpackage

>>> hdl/triple_copy_byte_voter_core.sv
// result: a transaction accepted at an edge is registered and shown on the output the next cycle
// throughput: one transaction per cycle; the result register is the only stage, and a new
//   transaction is taken whenever the result register is empty or being taken
// reset: synchronous active-high rst clears out_valid, the running sum, the
//   unrecoverable mark and both configuration registers
module triple_copy_byte_voter_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  copy_byte,
  input  logic [7:0]  inverted_byte,
  input  logic        last,
  input  logic [15:0] stored_sum,
  input  logic [15:0] copy_sum,
  input  logic [15:0] inverted_sum,
  input  logic [7:0]  tag_primary,
  input  logic [7:0]  tag_copy,
  input  logic [7:0]  tag_inverted,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  fixed_data,
  output logic [7:0]  fixed_copy,
  output logic [7:0]  fixed_inverted,
  output logic [2:0]  byte_status,
  output logic        done_res,
  output logic        tag_error,
  output logic        mem_error,
  output logic        data_error,
  output logic [15:0] new_sum
);

  logic [1:0]  mode;
  logic [7:0]  expected_tag;
  logic [15:0] running_sum;
  logic        unrecov_seen;
  logic [15:0] sum_next;
  logic        accept;

  tcbv_pkg::vote_res_t  vote;
  tcbv_pkg::rec_flags_t flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= tcbv_pkg::MODE_CHECK;
      expected_tag <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcbv_pkg::REG_MODE:         mode         <= cfg_data[1:0];
        tcbv_pkg::REG_EXPECTED_TAG: expected_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte vote and repair
  tcbv_vote u_vote (
    .mode          (mode),
    .unrecov_seen  (unrecov_seen),
    .data_byte     (data_byte),
    .copy_byte     (copy_byte),
    .inverted_byte (inverted_byte),
    .res           (vote)
  );

  // running sum including this byte
  assign sum_next = running_sum + {8'd0, vote.fixed_data};

  // end-of-record checks
  tcbv_check u_check (
    .mode         (mode),
    .expected_tag (expected_tag),
    .sum          (sum_next),
    .unrecov_any  (unrecov_seen | vote.unrecov),
    .stored_sum   (stored_sum),
    .copy_sum     (copy_sum),
    .inverted_sum (inverted_sum),
    .tag_primary  (tag_primary),
    .tag_copy     (tag_copy),
    .tag_inverted (tag_inverted),
    .flags        (flags)
  );

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // record state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      unrecov_seen <= 1'b0;
    end else if (accept) begin
      if (last) begin
        running_sum  <= '0;
        unrecov_seen <= 1'b0;
      end else begin
        running_sum  <= sum_next;
        unrecov_seen <= unrecov_seen | vote.unrecov;
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fixed_data     <= vote.fixed_data;
      fixed_copy     <= vote.fixed_copy;
      fixed_inverted <= vote.fixed_inverted;
      byte_status    <= vote.status;
      done_res       <= last;
      tag_error      <= last & flags.tag_error;
      mem_error      <= last & flags.mem_error;
      data_error     <= last & flags.data_error;
      new_sum        <= last ? sum_next : 16'd0;
    end
  end

endmodule

>>> hdl/tcbv_vote.sv
module tcbv_vote (
  input  logic [1:0]        mode,
  input  logic              unrecov_seen,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        copy_byte,
  input  logic [7:0]        inverted_byte,
  output tcbv_pkg::vote_res_t res
);

  logic [7:0] decoded;
  logic       dc, dv, cv;
  tcbv_pkg::status_t status;

  // decode the inverted copy and compare all pairs
  assign decoded = tcbv_pkg::BYTE_ONES - inverted_byte;
  assign dc = (data_byte == copy_byte);
  assign dv = (data_byte == decoded);
  assign cv = (copy_byte == decoded);

  // two-of-three classification
  always_comb begin
    priority if (dc && dv) status = tcbv_pkg::ST_AGREE;
    else if (dc)           status = tcbv_pkg::ST_INV_FIXED;
    else if (dv)           status = tcbv_pkg::ST_COPY_FIXED;
    else if (cv)           status = tcbv_pkg::ST_DATA_FIXED;
    else                   status = tcbv_pkg::ST_UNRECOV;
  end

  // repair the bytes or refresh the copies
  always_comb begin
    res.fixed_data     = data_byte;
    res.fixed_copy     = copy_byte;
    res.fixed_inverted = inverted_byte;
    res.status         = status;
    res.unrecov        = 1'b0;
    if (mode == tcbv_pkg::MODE_REFRESH) begin
      res.fixed_copy     = data_byte;
      res.fixed_inverted = tcbv_pkg::BYTE_ONES - data_byte;
      res.status         = tcbv_pkg::ST_AGREE;
    end else begin
      res.unrecov = (status == tcbv_pkg::ST_UNRECOV);
      if (mode == tcbv_pkg::MODE_REPAIR && !unrecov_seen) begin
        unique case (status)
          tcbv_pkg::ST_INV_FIXED:  res.fixed_inverted = tcbv_pkg::BYTE_ONES - data_byte;
          tcbv_pkg::ST_COPY_FIXED: res.fixed_copy     = data_byte;
          tcbv_pkg::ST_DATA_FIXED: res.fixed_data     = copy_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hdl/tcbv_check.sv
module tcbv_check (
  input  logic [1:0]         mode,
  input  logic [7:0]         expected_tag,
  input  logic [15:0]        sum,
  input  logic               unrecov_any,
  input  logic [15:0]        stored_sum,
  input  logic [15:0]        copy_sum,
  input  logic [15:0]        inverted_sum,
  input  logic [7:0]         tag_primary,
  input  logic [7:0]         tag_copy,
  input  logic [7:0]         tag_inverted,
  output tcbv_pkg::rec_flags_t flags
);

  logic [15:0] sum_dec;
  logic [15:0] voted;
  logic        vote_ok;
  logic [7:0]  tag_dec;

  assign sum_dec = tcbv_pkg::SUM_ONES - inverted_sum;
  assign tag_dec = tcbv_pkg::BYTE_ONES - tag_inverted;

  // two-of-three vote on the stored sums
  always_comb begin
    vote_ok = 1'b1;
    priority if (stored_sum == copy_sum || stored_sum == sum_dec) voted = stored_sum;
    else if (copy_sum == sum_dec)                                  voted = copy_sum;
    else begin
      voted   = stored_sum;
      vote_ok = 1'b0;
    end
  end

  // record-level flags, quiet in refresh mode
  always_comb begin
    flags = '0;
    if (mode != tcbv_pkg::MODE_REFRESH) begin
      flags.tag_error  = (tag_primary != tag_copy) || (tag_primary != tag_dec);
      flags.data_error = (tag_primary != expected_tag) || (sum != stored_sum);
      flags.mem_error  = unrecov_any ||
                         (mode == tcbv_pkg::MODE_REPAIR && (!vote_ok || voted != sum));
    end
  end

endmodule

>>> hdl/tcbv_checker.sv
module tcbv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  fixed_data,
  input logic [2:0]  byte_status,
  input logic        done_res,
  input logic        tag_error,
  input logic        mem_error,
  input logic        data_error,
  input logic [15:0] new_sum
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fixed_data) && $stable(new_sum))
    else $error("stalled result changed");

  // record flags and sum only on the last transaction
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> new_sum == 16'd0 && !tag_error && !mem_error && !data_error)
    else $error("record fields set on a non-last result");

  // an unrecoverable last byte must raise mem_error
  a_unrec: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && byte_status == tcbv_pkg::ST_UNRECOV |-> mem_error)
    else $error("unrecoverable byte without mem_error");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind triple_copy_byte_voter_core tcbv_checker u_tcbv_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .fixed_data  (fixed_data),
  .byte_status (byte_status),
  .done_res    (done_res),
  .tag_error   (tag_error),
  .mem_error   (mem_error),
  .data_error  (data_error),
  .new_sum     (new_sum)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

// one byte position of a record as offered to the block
typedef struct packed {
  logic [7:0]  data;
  logic [7:0]  copy;
  logic [7:0]  inverted;
  logic        last;
  logic [15:0] stored_sum;
  logic [15:0] copy_sum;
  logic [15:0] inverted_sum;
  logic [7:0]  tag_p;
  logic [7:0]  tag_c;
  logic [7:0]  tag_i;
} scrub_item_t;

// one voted byte as returned by the block
typedef struct packed {
  logic [7:0]        fixed_data;
  logic [7:0]        fixed_copy;
  logic [7:0]        fixed_inverted;
  tcbv_pkg::status_t status;
  logic              done;
  logic              tag_error;
  logic              mem_error;
  logic              data_error;
  logic [15:0]       new_sum;
} scrub_res_t;

class scrub_scoreboard;
  logic [1:0]  cur_mode;
  logic [7:0]  tag_want;
  logic [15:0] sum_acc;
  logic        bad_seen;
  scrub_res_t  expected_votes[$];
  int          failures;
  int          reported;

  function new();
    cur_mode = tcbv_pkg::MODE_CHECK;
    tag_want = '0;
    sum_acc  = '0;
    bad_seen = 1'b0;
    failures = 0;
    reported = 0;
  endfunction

  function void set_reg(input logic idx, input logic [7:0] val);
    if (idx == tcbv_pkg::REG_MODE) cur_mode = val[1:0];
    else tag_want = val;
  endfunction

  // vote, repair and record checks for one accepted transaction
  function void note_item(input scrub_item_t it);
    scrub_res_t  r;
    logic [7:0]  d, c, iv, v;
    logic [15:0] s3, voted;
    logic        vote_ok;
    d  = it.data;
    c  = it.copy;
    iv = it.inverted;
    v  = tcbv_pkg::BYTE_ONES - iv;
    r  = '0;
    r.status = tcbv_pkg::ST_AGREE;
    if (cur_mode == tcbv_pkg::MODE_REFRESH) begin
      c  = d;
      iv = tcbv_pkg::BYTE_ONES - d;
    end else begin
      if (d == c && d == v) r.status = tcbv_pkg::ST_AGREE;
      else if (d == c) r.status = tcbv_pkg::ST_INV_FIXED;
      else if (d == v) r.status = tcbv_pkg::ST_COPY_FIXED;
      else if (c == v) r.status = tcbv_pkg::ST_DATA_FIXED;
      else r.status = tcbv_pkg::ST_UNRECOV;
      // repair stops once the record has an unrecoverable byte
      if (cur_mode == tcbv_pkg::MODE_REPAIR && !bad_seen) begin
        case (r.status)
          tcbv_pkg::ST_INV_FIXED:  iv = tcbv_pkg::BYTE_ONES - d;
          tcbv_pkg::ST_COPY_FIXED: c = d;
          tcbv_pkg::ST_DATA_FIXED: d = c;
          default: ;
        endcase
      end
      if (r.status == tcbv_pkg::ST_UNRECOV) bad_seen = 1'b1;
    end
    sum_acc = sum_acc + d;
    r.fixed_data     = d;
    r.fixed_copy     = c;
    r.fixed_inverted = iv;
    r.done           = it.last;
    // end of record flags
    if (it.last) begin
      r.new_sum = sum_acc;
      if (cur_mode != tcbv_pkg::MODE_REFRESH) begin
        r.tag_error  = (it.tag_p != it.tag_c) ||
                       (it.tag_p != tcbv_pkg::BYTE_ONES - it.tag_i);
        r.data_error = (it.tag_p != tag_want) || (sum_acc != it.stored_sum);
        r.mem_error  = bad_seen;
        if (cur_mode == tcbv_pkg::MODE_REPAIR) begin
          s3      = tcbv_pkg::SUM_ONES - it.inverted_sum;
          vote_ok = 1'b1;
          voted   = '0;
          if (it.stored_sum == it.copy_sum || it.stored_sum == s3) voted = it.stored_sum;
          else if (it.copy_sum == s3) voted = it.copy_sum;
          else vote_ok = 1'b0;
          if (!vote_ok || voted != sum_acc) r.mem_error = 1'b1;
        end
      end
      sum_acc  = '0;
      bad_seen = 1'b0;
    end
    expected_votes.push_back(r);
  endfunction

  function string show(input scrub_res_t r);
    return $sformatf("data=%h copy=%h inv=%h st=%0d done=%b tag=%b mem=%b dat=%b sum=%h",
                     r.fixed_data, r.fixed_copy, r.fixed_inverted, r.status, r.done,
                     r.tag_error, r.mem_error, r.data_error, r.new_sum);
  endfunction

  function void check_result(input scrub_res_t got);
    scrub_res_t exp;
    if (expected_votes.size() == 0) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result: %s", show(got));
      end
      return;
    end
    exp = expected_votes.pop_front();
    if (got.fixed_data !== exp.fixed_data || got.fixed_copy !== exp.fixed_copy ||
        got.fixed_inverted !== exp.fixed_inverted || got.status !== exp.status ||
        got.done !== exp.done || got.tag_error !== exp.tag_error ||
        got.mem_error !== exp.mem_error || got.data_error !== exp.data_error ||
        got.new_sum !== exp.new_sum) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("mismatch at %0t", $realtime);
        $display("  expected %s", show(exp));
        $display("  actual   %s", show(got));
      end
    end
  endfunction
endclass

module testbench;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 1530;
  localparam int          SEGMENTS     = 12;
  localparam int          LONG_HOLD    = 300;
  localparam logic [1:0]  MODE_ALIAS   = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  scrub_item_t offer;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  fixed_data;
  logic [7:0]  fixed_copy;
  logic [7:0]  fixed_inverted;
  logic [2:0]  byte_status;
  logic        done_res;
  logic        tag_error;
  logic        mem_error;
  logic        data_error;
  logic [15:0] new_sum;

  scrub_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int sent;
  int cycles;

  logic [1:0] seg_modes [4] = '{tcbv_pkg::MODE_REPAIR, tcbv_pkg::MODE_CHECK,
                                tcbv_pkg::MODE_REFRESH, MODE_ALIAS};

  triple_copy_byte_voter_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (offer.data),
    .copy_byte      (offer.copy),
    .inverted_byte  (offer.inverted),
    .last           (offer.last),
    .stored_sum     (offer.stored_sum),
    .copy_sum       (offer.copy_sum),
    .inverted_sum   (offer.inverted_sum),
    .tag_primary    (offer.tag_p),
    .tag_copy       (offer.tag_c),
    .tag_inverted   (offer.tag_i),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .fixed_data     (fixed_data),
    .fixed_copy     (fixed_copy),
    .fixed_inverted (fixed_inverted),
    .byte_status    (byte_status),
    .done_res       (done_res),
    .tag_error      (tag_error),
    .mem_error      (mem_error),
    .data_error     (data_error),
    .new_sum        (new_sum)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin : watch_ports
    scrub_res_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.fixed_data     = fixed_data;
        got.fixed_copy     = fixed_copy;
        got.fixed_inverted = fixed_inverted;
        got.status         = tcbv_pkg::status_t'(byte_status);
        got.done           = done_res;
        got.tag_error      = tag_error;
        got.mem_error      = mem_error;
        got.data_error     = data_error;
        got.new_sum        = new_sum;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_item(offer);
    end
  end

  function automatic scrub_item_t make_item(input logic [7:0] d, c, iv, input logic lst,
                                            input logic [15:0] s1, s2, s3,
                                            input logic [7:0] tp, tc, ti);
    scrub_item_t it;
    it = '{d, c, iv, lst, s1, s2, s3, tp, tc, ti};
    return it;
  endfunction

  function automatic scrub_item_t random_item();
    scrub_item_t it;
    it.data         = 8'($urandom);
    it.copy         = 8'($urandom);
    it.inverted     = 8'($urandom);
    it.last         = 1'($urandom);
    it.stored_sum   = 16'($urandom);
    it.copy_sum     = 16'($urandom);
    it.inverted_sum = 16'($urandom);
    it.tag_p        = 8'($urandom);
    it.tag_c        = 8'($urandom);
    it.tag_i        = 8'($urandom);
    return it;
  endfunction

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_item(input scrub_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    offer    <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // well-formed record with occasional damage to bytes, sums and tags
  task automatic send_record(input int len);
    scrub_item_t it;
    logic [7:0]  t, m1, m2, tag;
    logic [15:0] truth_sum;
    int          r;
    truth_sum = '0;
    tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : sb.tag_want;
    for (int i = 0; i < len; i++) begin
      it = random_item();
      t  = 8'($urandom);
      m1 = 8'($urandom_range(1, 255));
      m2 = 8'($urandom_range(1, 255));
      truth_sum   = truth_sum + t;
      it.data     = t;
      it.copy     = t;
      it.inverted = tcbv_pkg::BYTE_ONES - t;
      it.last     = (i == len - 1);
      r = $urandom_range(0, 99);
      if (r >= 94) begin
        it.copy     = it.copy ^ m1;
        it.inverted = it.inverted ^ m2;
      end else if (r >= 86) begin
        it.inverted = it.inverted ^ m1;
      end else if (r >= 78) begin
        it.copy = it.copy ^ m1;
      end else if (r >= 70) begin
        it.data = it.data ^ m1;
      end
      if (it.last) begin
        if ($urandom_range(0, 99) < 85) it.stored_sum = truth_sum;
        if ($urandom_range(0, 99) < 85) it.copy_sum = truth_sum;
        if ($urandom_range(0, 99) < 85) it.inverted_sum = tcbv_pkg::SUM_ONES - truth_sum;
        if ($urandom_range(0, 99) < 90) it.tag_p = tag;
        if ($urandom_range(0, 99) < 90) it.tag_c = tag;
        if ($urandom_range(0, 99) < 90) it.tag_i = tcbv_pkg::BYTE_ONES - tag;
      end
      send_item(it);
    end
  endtask

  // let every expected transaction come back before touching registers
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_votes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // main sequence
  initial begin
    int         goal;
    int         len;
    logic [7:0] seg_tag;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    offer         = '0;
    send_idle_pct = 31;
    recv_idle_pct = 82;
    hold_requests = 0;
    sent          = 0;
    sb            = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: repair mode, every vote outcome and the record flags
    write_reg(tcbv_pkg::REG_MODE, {6'd0, tcbv_pkg::MODE_REPAIR});
    write_reg(tcbv_pkg::REG_EXPECTED_TAG, 8'h00);
    send_item(make_item(8'h00, 8'h00, 8'hff, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'hff, 8'hff, 8'h00, 1'b0, 16'hffff, 16'hffff, 16'hffff,
                        8'hff, 8'hff, 8'hff));
    send_item(make_item(8'h3c, 8'h3c, 8'h00, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'h5a, 8'h00, 8'ha5, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'hff, 8'h12, 8'hed, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    // unrecoverable byte, then repair is frozen for the rest of the record
    send_item(make_item(8'h01, 8'h02, 8'hfc, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'h40, 8'h40, 8'h00, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'hff, 8'hff, 8'h00, 1'b1, 16'hffff, 16'hffff, 16'hffff,
                        8'hff, 8'hff, 8'hff));
    // single-byte records exercising the sum vote and tag checks
    send_item(make_item(8'h00, 8'h00, 8'h00, 1'b1, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'h10, 8'h10, 8'hef, 1'b1, 16'h0010, 16'h0010, 16'hffef,
                        8'h00, 8'h00, 8'hff));
    send_item(make_item(8'h20, 8'h20, 8'hdf, 1'b1, 16'h0001, 16'h0002, 16'hfffc,
                        8'h00, 8'h00, 8'hff));
    send_item(make_item(8'h30, 8'h30, 8'hcf, 1'b1, 16'h0099, 16'h0099, 16'h0000,
                        8'h00, 8'h00, 8'hff));
    send_item(make_item(8'h30, 8'h30, 8'hcf, 1'b1, 16'h0031, 16'h0030, 16'hffcf,
                        8'h00, 8'h00, 8'hff));
    // repaired primary feeds the sum
    send_item(make_item(8'hff, 8'h77, 8'h88, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'h01, 8'h01, 8'hfe, 1'b1, 16'h0078, 16'h0078, 16'hff87,
                        8'h00, 8'h00, 8'hff));
    send_item(make_item(8'h00, 8'h00, 8'hff, 1'b1, 16'h0000, 16'h0000, 16'hffff,
                        8'h00, 8'h01, 8'hff));
    drain();

    // directed: mode code three acts as check
    write_reg(tcbv_pkg::REG_MODE, {6'd0, MODE_ALIAS});
    write_reg(tcbv_pkg::REG_EXPECTED_TAG, 8'hff);
    send_item(make_item(8'hff, 8'h12, 8'hed, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'h01, 8'h02, 8'hfc, 1'b1, 16'h0100, 16'h0100, 16'hfeff,
                        8'hff, 8'hff, 8'h00));
    drain();

    // directed: refresh rebuilds both backups
    write_reg(tcbv_pkg::REG_MODE, {6'd0, tcbv_pkg::MODE_REFRESH});
    send_item(make_item(8'ha5, 8'h00, 8'h00, 1'b0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(8'h01, 8'h02, 8'hfc, 1'b1, 16'h1234, 16'h5678, 16'h9abc,
                        8'h11, 8'h22, 8'h33));

    // random records over several register settings and idle patterns
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg / 4)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg % 3)
        0: seg_tag = 8'h00;
        1: seg_tag = 8'hff;
        default: seg_tag = 8'($urandom);
      endcase
      write_reg(tcbv_pkg::REG_MODE, {6'd0, seg_modes[seg % 4]});
      write_reg(tcbv_pkg::REG_EXPECTED_TAG, seg_tag);
      // back up the output while the sender keeps offering
      if (seg == 8) hold_requests++;
      goal = sent + RANDOM_ITEMS / SEGMENTS;
      while (sent < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(random_item());
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          send_record(len);
        end
      end
    end
    drain();
    repeat (10) @(posedge clk);

    if (sb.failures == 0 && sb.expected_votes.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
